// ===== rtl/core/aann_pkg.sv =====
// Package for the alarm annunciator with acknowledge.
// Holds the channel count, status codes, the count record and small helpers.
// Used by every module in rtl/core; depends on nothing.
package aann_pkg;

  localparam int CHANNELS = 8;
  localparam int VIS_CH   = (CHANNELS < 8) ? CHANNELS : 8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WARN  = 2'd1;
  localparam logic [1:0] ST_ALERT = 2'd2;
  localparam logic [1:0] ST_STALE = 2'd3;

  localparam logic [1:0] SEV_NONE  = 2'd0;
  localparam logic [1:0] SEV_WARN  = 2'd1;
  localparam logic [1:0] SEV_ALERT = 2'd2;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_ACK    = 1'b1;

  localparam logic [3:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic [3:0] ok;
    logic [3:0] warn;
    logic [3:0] alert;
    logic [3:0] stale;
    logic [3:0] warn_un;
    logic [3:0] alert_un;
  } counts_t;

  function automatic logic [1:0] sev_of(input logic [1:0] st);
    logic [1:0] sev;
    case (st)
      ST_WARN:  sev = SEV_WARN;
      ST_ALERT: sev = SEV_ALERT;
      default:  sev = SEV_NONE;
    endcase
    return sev;
  endfunction

  function automatic logic [3:0] sat_inc(input logic [3:0] c, input logic en);
    logic [3:0] r;
    r = (en && (c != CNT_MAX)) ? c + 4'd1 : c;
    return r;
  endfunction

endpackage

// ===== rtl/core/aann_if.sv =====
// Handshake interfaces for the request and result channels.
// Depends on nothing; the payload widths are fixed by the field list.
interface aann_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] status_vector;
  modport source (output valid, mode, status_vector, input ready);
  modport sink   (input valid, mode, status_vector, output ready);
endinterface

interface aann_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] status_out;
  logic [7:0]  unacked_mask;
  logic [3:0]  ok_count;
  logic [3:0]  warn_count;
  logic [3:0]  alert_count;
  logic [3:0]  stale_count;
  logic [3:0]  warn_unacked_count;
  logic [3:0]  alert_unacked_count;
  modport source (output valid, status_out, unacked_mask, ok_count, warn_count,
                  alert_count, stale_count, warn_unacked_count,
                  alert_unacked_count, input ready);
  modport sink   (input valid, status_out, unacked_mask, ok_count, warn_count,
                  alert_count, stale_count, warn_unacked_count,
                  alert_unacked_count, output ready);
endinterface

// ===== rtl/core/alarm_annunciator_ack_top.sv =====
// Top level of the alarm annunciator: a row of channel cells and a result register.
// Depends on aann_pkg, aann_if and aann_cell.
//
//   channel | dir | payload                                   | handshake
//   in_if   | in  | mode, status_vector                       | valid / ready
//   out_if  | out | status_out, unacked_mask, six counts      | valid / ready
//
// One request a cycle unless out_if stalls; its result shows in the next cycle.
// The cells update their state and the counts ripple along the row in the
// accepting cycle, and the result register is loaded at the same edge.
// A request is taken whenever the result register is empty or being emptied.
// Reset sets every channel to stale with nothing acknowledged, output empty.
module alarm_annunciator_ack_top (
  input  logic        clk,
  input  logic        rst_n,
  aann_in_if.sink     in_if,
  aann_out_if.source  out_if
);

  localparam int N = aann_pkg::CHANNELS;

  aann_pkg::counts_t cnt_chain [0:N];
  logic [1:0]        st_nxt    [0:N-1];
  logic              un_nxt    [0:N-1];
  logic              accept;
  logic [15:0]       status_word;
  logic [7:0]        mask_word;

  logic              out_valid_r;
  logic [15:0]       status_r;
  logic [7:0]        mask_r;
  aann_pkg::counts_t cnt_r;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign cnt_chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [1:0] st_in;
    if (i < 8) begin : g_vis
      assign st_in = in_if.status_vector[2*i +: 2];
    end else begin : g_hid
      assign st_in = aann_pkg::ST_OK;
    end
    aann_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .accept      (accept),
      .mode        (in_if.mode),
      .status_in   (st_in),
      .cnt_in      (cnt_chain[i]),
      .cnt_out     (cnt_chain[i+1]),
      .status_nxt  (st_nxt[i]),
      .unacked_nxt (un_nxt[i])
    );
  end

  for (genvar i = 0; i < 8; i++) begin : g_word
    if (i < aann_pkg::VIS_CH) begin : g_on
      assign status_word[2*i +: 2] = st_nxt[i];
      assign mask_word[i]          = un_nxt[i];
    end else begin : g_off
      assign status_word[2*i +: 2] = 2'b00;
      assign mask_word[i]          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_word;
      mask_r   <= mask_word;
      cnt_r    <= cnt_chain[N];
    end
  end

  assign out_if.valid               = out_valid_r;
  assign out_if.status_out          = status_r;
  assign out_if.unacked_mask        = mask_r;
  assign out_if.ok_count            = cnt_r.ok;
  assign out_if.warn_count          = cnt_r.warn;
  assign out_if.alert_count         = cnt_r.alert;
  assign out_if.stale_count         = cnt_r.stale;
  assign out_if.warn_unacked_count  = cnt_r.warn_un;
  assign out_if.alert_unacked_count = cnt_r.alert_un;

endmodule

// ===== rtl/core/aann_cell.sv =====
// One channel cell: holds the channel status and acknowledged severity.
// Adds its own contribution to the running counts handed on along the row.
// Depends on aann_pkg.
module aann_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              mode,
  input  logic [1:0]        status_in,
  input  aann_pkg::counts_t cnt_in,
  output aann_pkg::counts_t cnt_out,
  output logic [1:0]        status_nxt,
  output logic              unacked_nxt
);

  logic [1:0] status_r;
  logic [1:0] acked_r;
  logic [1:0] acked_nxt;
  logic [1:0] sev_new;
  logic [1:0] sev_cur;

  always_comb begin
    sev_cur = aann_pkg::sev_of(status_r);
    sev_new = aann_pkg::sev_of(status_in);
    if (mode == aann_pkg::MODE_ACK) begin
      status_nxt = status_r;
      acked_nxt  = sev_cur;
    end else begin
      status_nxt = status_in;
      acked_nxt  = (sev_new < acked_r) ? sev_new : acked_r;
    end
  end

  always_comb begin
    logic [1:0] sev;
    sev         = aann_pkg::sev_of(status_nxt);
    unacked_nxt = (sev != aann_pkg::SEV_NONE) && (sev > acked_nxt);
    cnt_out.ok       = aann_pkg::sat_inc(cnt_in.ok, status_nxt == aann_pkg::ST_OK);
    cnt_out.warn     = aann_pkg::sat_inc(cnt_in.warn, status_nxt == aann_pkg::ST_WARN);
    cnt_out.alert    = aann_pkg::sat_inc(cnt_in.alert, status_nxt == aann_pkg::ST_ALERT);
    cnt_out.stale    = aann_pkg::sat_inc(cnt_in.stale, status_nxt == aann_pkg::ST_STALE);
    cnt_out.warn_un  = aann_pkg::sat_inc(cnt_in.warn_un,
                         unacked_nxt && (status_nxt == aann_pkg::ST_WARN));
    cnt_out.alert_un = aann_pkg::sat_inc(cnt_in.alert_un,
                         unacked_nxt && (status_nxt == aann_pkg::ST_ALERT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= aann_pkg::ST_STALE;
      acked_r  <= aann_pkg::SEV_NONE;
    end else if (accept) begin
      status_r <= status_nxt;
      acked_r  <= acked_nxt;
    end
  end

endmodule

// ===== rtl/core/aann_checker.sv =====
// Port-level checks for the alarm annunciator, bound to the top level.
// Depends on aann_pkg and on the port names of alarm_annunciator_ack_top.
module aann_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] status_out,
  input logic [7:0]  unacked_mask,
  input logic [3:0]  ok_count,
  input logic [3:0]  warn_count,
  input logic [3:0]  alert_count,
  input logic [3:0]  stale_count,
  input logic [3:0]  warn_unacked_count,
  input logic [3:0]  alert_unacked_count
);

  localparam bit SMALL = (aann_pkg::CHANNELS <= 8);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status_out)
      && $stable(unacked_mask))
    else $error("Result changed while stalled.");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == aann_pkg::MODE_ACK)
      |=> out_valid && (unacked_mask == 8'd0)
        && (warn_unacked_count == 4'd0) && (alert_unacked_count == 4'd0))
    else $error("Alarms left unacknowledged after an acknowledge request.");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL |-> ({2'b00, ok_count} + {2'b00, warn_count}
      + {2'b00, alert_count} + {2'b00, stale_count}) == 6'(aann_pkg::CHANNELS))
    else $error("Status counts do not add up to the channel count.");

  a_mask_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL |-> ($countones(unacked_mask)
      == (int'(warn_unacked_count) + int'(alert_unacked_count)))
      && (warn_unacked_count <= warn_count) && (alert_unacked_count <= alert_count))
    else $error("Unacknowledged mask and counts disagree.");

endmodule

bind alarm_annunciator_ack_top aann_checker u_aann_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_if.valid),
  .in_ready            (in_if.ready),
  .in_mode             (in_if.mode),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .status_out          (out_if.status_out),
  .unacked_mask        (out_if.unacked_mask),
  .ok_count            (out_if.ok_count),
  .warn_count          (out_if.warn_count),
  .alert_count         (out_if.alert_count),
  .stale_count         (out_if.stale_count),
  .warn_unacked_count  (out_if.warn_unacked_count),
  .alert_unacked_count (out_if.alert_unacked_count)
);
